// ===== design/detection_head_decode_defines.svh =====
// assertion macros shared by the detection head decoder
`ifndef DETECTION_HEAD_DECODE_DEFINES_SVH
`define DETECTION_HEAD_DECODE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define DHD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("detection_head_decode: assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define DHD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("detection_head_decode: assertion failed");

`endif

// ===== design/dhd_pkg.sv =====
// types and constants of the detection head decoder
`timescale 1ns / 1ps

package dhd_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int MAX_CLASSES_DEF   = 255;

    localparam int VALUE_W    = 32;
    localparam int ANCHOR_W   = 16;
    localparam int LABEL_W    = 8;
    localparam int SCORE_W    = 31;
    localparam int EDGE_W     = 30;
    localparam int SCALE_W    = 24;
    localparam int SIZE_W     = 14;
    localparam int THRESH_W   = 17;
    localparam int POS_W      = 9;
    localparam int BOX_VALUES = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_X_SCALE,
        CFG_Y_SCALE,
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_SCORE_THRESHOLD,
        CFG_NUM_CLASSES,
        CFG_NUM_ANCHORS
    } t_cfg_index;

    localparam logic [SCALE_W-1:0]  RST_X_SCALE         = 24'd65536;
    localparam logic [SCALE_W-1:0]  RST_Y_SCALE         = 24'd65536;
    localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH     = 14'd640;
    localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT    = 14'd640;
    localparam logic [THRESH_W-1:0] RST_SCORE_THRESHOLD = 17'd16384;
    localparam logic [LABEL_W-1:0]  RST_NUM_CLASSES     = 8'd80;
    localparam logic [ANCHOR_W-1:0] RST_NUM_ANCHORS     = 16'd8400;

    // settings seen by the front
    typedef struct packed {
        logic [THRESH_W-1:0] score_threshold;
        logic [LABEL_W-1:0]  num_classes;
        logic [ANCHOR_W-1:0] num_anchors;
    } t_front_cfg;

    // settings seen by the back
    typedef struct packed {
        logic [SCALE_W-1:0] x_scale;
        logic [SCALE_W-1:0] y_scale;
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
    } t_geom_cfg;

    // one closed row that passed the threshold
    typedef struct packed {
        logic [ANCHOR_W-1:0] anchor;
        logic [LABEL_W-1:0]  label;
        logic [SCORE_W-1:0]  score;
        logic [VALUE_W-1:0]  cx;
        logic [VALUE_W-1:0]  cy;
        logic [VALUE_W-1:0]  w;
        logic [VALUE_W-1:0]  h;
    } t_job;

    typedef struct packed {
        logic [ANCHOR_W-1:0] anchor;
        logic [LABEL_W-1:0]  label;
        logic [SCORE_W-1:0]  score;
        logic [EDGE_W-1:0]   left;
        logic [EDGE_W-1:0]   top;
        logic [EDGE_W-1:0]   box_width;
        logic [EDGE_W-1:0]   box_height;
    } t_result;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_queue_status;

endpackage

// ===== design/dhd_front.sv =====
// front: row position tracking, box capture, running arg-max and threshold test
`timescale 1ns / 1ps

module dhd_front import dhd_pkg::*; #(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_front_cfg         i_cfg,
    input  logic               i_valid,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_queue_full,
    output logic               o_stall,
    output logic               o_push,
    output t_job               o_job
);

    localparam logic [LABEL_W-1:0] MAX_CLS = LABEL_W'(MAX_CLASSES);

    logic [POS_W-1:0]    r_pos, n_pos;
    logic [ANCHOR_W-1:0] r_anchor, n_anchor;
    logic [VALUE_W-1:0]  r_box [BOX_VALUES];
    logic [VALUE_W-1:0]  r_best, n_best;
    logic [LABEL_W-1:0]  r_label, n_label;

    logic [LABEL_W-1:0] w_classes;
    logic [POS_W-1:0]   w_last;
    logic [POS_W-1:0]   w_pos_eff;
    logic [LABEL_W-1:0] w_cls;
    logic               w_accept;
    logic               w_in_box;
    logic               w_take;
    logic               w_close;

    assign o_stall  = i_queue_full;
    assign w_accept = i_valid && !i_queue_full;
    assign w_in_box = r_pos < POS_W'(BOX_VALUES);

    always_comb begin
        if (i_cfg.num_classes == '0) begin
            w_classes = LABEL_W'(1);
        end else if (i_cfg.num_classes > MAX_CLS) begin
            w_classes = MAX_CLS;
        end else begin
            w_classes = i_cfg.num_classes;
        end
    end

    assign w_last    = POS_W'(BOX_VALUES - 1) + {1'b0, w_classes};
    // a row shortened mid-way closes on the next score
    assign w_pos_eff = (r_pos > w_last) ? w_last : r_pos;
    assign w_cls     = LABEL_W'(w_pos_eff - POS_W'(BOX_VALUES));
    assign w_take    = (w_cls == '0) || ($signed(i_value) > $signed(r_best));
    assign w_close   = w_accept && !w_in_box && (w_pos_eff == w_last);

    always_comb begin
        n_best   = w_take ? i_value : r_best;
        n_label  = w_take ? w_cls : r_label;
        n_pos    = r_pos;
        n_anchor = r_anchor;
        if (w_accept) begin
            if (w_in_box) begin
                n_pos = r_pos + POS_W'(1);
            end else if (w_pos_eff != w_last) begin
                n_pos = w_pos_eff + POS_W'(1);
            end else begin
                n_pos = '0;
                if (({1'b0, r_anchor} + (ANCHOR_W+1)'(1)) >= {1'b0, i_cfg.num_anchors}) begin
                    n_anchor = '0;
                end else begin
                    n_anchor = r_anchor + ANCHOR_W'(1);
                end
            end
        end
    end

    assign o_push = w_close &&
                    ($signed(n_best) > $signed({{(VALUE_W-THRESH_W){1'b0}},
                                                i_cfg.score_threshold}));

    always_comb begin
        o_job.anchor = r_anchor;
        o_job.label  = n_label;
        o_job.score  = n_best[SCORE_W-1:0];
        o_job.cx     = r_box[0];
        o_job.cy     = r_box[1];
        o_job.w      = r_box[2];
        o_job.h      = r_box[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_anchor <= '0;
        end else begin
            r_pos    <= n_pos;
            r_anchor <= n_anchor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_box) begin
            r_box[r_pos[1:0]] <= i_value;
        end
        if (w_accept && !w_in_box) begin
            r_best  <= n_best;
            r_label <= n_label;
        end
    end

endmodule

// ===== design/dhd_queue.sv =====
// short job queue between front and back
`timescale 1ns / 1ps

module dhd_queue import dhd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output t_job          o_job,
    output t_queue_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_job              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_valid        = r_count != '0;
    assign o_job          = r_mem[r_rd];
    assign o_status.full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_status.count = r_count;

    always_comb begin
        n_wr    = i_push ? ptr_inc(r_wr) : r_wr;
        n_rd    = i_pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== design/dhd_back.sv =====
// back: corner arithmetic, scaling, clamping and the output register
`timescale 1ns / 1ps

module dhd_back import dhd_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_geom_cfg i_cfg,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    output t_result   o_result,
    input  logic      i_stall
);

    localparam int RAW_W  = VALUE_W + 1;
    localparam int PROD_W = RAW_W + SCALE_W + 1;
    localparam int LIM_W  = SIZE_W + FRACTION_BITS;
    localparam int WIDE_W = LIM_W + EDGE_W;

    // stage 1: corners in model coordinates
    logic                     r_s1_valid;
    logic [ANCHOR_W-1:0]      r_s1_anchor;
    logic [LABEL_W-1:0]       r_s1_label;
    logic [SCORE_W-1:0]       r_s1_score;
    logic signed [RAW_W-1:0]  r_s1_x0, r_s1_x1, r_s1_y0, r_s1_y1;

    // stage 2: scaled corners, floor-shifted
    logic                     r_s2_valid;
    logic [ANCHOR_W-1:0]      r_s2_anchor;
    logic [LABEL_W-1:0]       r_s2_label;
    logic [SCORE_W-1:0]       r_s2_score;
    logic signed [PROD_W-1:0] r_s2_x0, r_s2_x1, r_s2_y0, r_s2_y1;

    logic    r_out_valid;
    t_result r_out;

    logic out_ready, s2_ready, s1_ready;

    logic signed [RAW_W-1:0]  w_cx, w_cy, w_hw, w_hh;
    logic signed [PROD_W-1:0] w_xs, w_ys;
    logic [LIM_W-1:0]         w_xlim, w_ylim;
    logic [LIM_W-1:0]         w_cx0, w_cx1, w_cy0, w_cy1;

    function automatic logic [LIM_W-1:0] clamp_edge(input logic signed [PROD_W-1:0] v,
                                                    input logic [LIM_W-1:0] lim);
        logic signed [PROD_W-1:0] lim_ext;
        lim_ext = $signed({{(PROD_W-LIM_W){1'b0}}, lim});
        if (v < 0) begin
            return '0;
        end else if (v > lim_ext) begin
            return lim;
        end else begin
            return v[LIM_W-1:0];
        end
    endfunction

    function automatic logic [EDGE_W-1:0] to_edge(input logic [LIM_W-1:0] v);
        logic [WIDE_W-1:0] wide;
        wide = {{EDGE_W{1'b0}}, v};
        return wide[EDGE_W-1:0];
    endfunction

    assign out_ready = !r_out_valid || !i_stall;
    assign s2_ready  = !r_s2_valid || out_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;
    assign o_pop     = i_job_valid && s1_ready;

    assign w_cx = $signed({i_job.cx[VALUE_W-1], i_job.cx});
    assign w_cy = $signed({i_job.cy[VALUE_W-1], i_job.cy});
    // floor of half the size
    assign w_hw = $signed({{2{i_job.w[VALUE_W-1]}}, i_job.w[VALUE_W-1:1]});
    assign w_hh = $signed({{2{i_job.h[VALUE_W-1]}}, i_job.h[VALUE_W-1:1]});

    assign w_xs = $signed({{(PROD_W-SCALE_W){1'b0}}, i_cfg.x_scale});
    assign w_ys = $signed({{(PROD_W-SCALE_W){1'b0}}, i_cfg.y_scale});

    assign w_xlim = {i_cfg.image_width, {FRACTION_BITS{1'b0}}};
    assign w_ylim = {i_cfg.image_height, {FRACTION_BITS{1'b0}}};

    assign w_cx0 = clamp_edge(r_s2_x0, w_xlim);
    assign w_cx1 = clamp_edge(r_s2_x1, w_xlim);
    assign w_cy0 = clamp_edge(r_s2_y0, w_ylim);
    assign w_cy1 = clamp_edge(r_s2_y1, w_ylim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_job_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_anchor <= i_job.anchor;
            r_s1_label  <= i_job.label;
            r_s1_score  <= i_job.score;
            r_s1_x0     <= w_cx - w_hw;
            r_s1_x1     <= w_cx + w_hw;
            r_s1_y0     <= w_cy - w_hh;
            r_s1_y1     <= w_cy + w_hh;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_anchor <= r_s1_anchor;
            r_s2_label  <= r_s1_label;
            r_s2_score  <= r_s1_score;
            // arithmetic shift right is the floor division
            r_s2_x0 <= (PROD_W'(r_s1_x0) * w_xs) >>> FRACTION_BITS;
            r_s2_x1 <= (PROD_W'(r_s1_x1) * w_xs) >>> FRACTION_BITS;
            r_s2_y0 <= (PROD_W'(r_s1_y0) * w_ys) >>> FRACTION_BITS;
            r_s2_y1 <= (PROD_W'(r_s1_y1) * w_ys) >>> FRACTION_BITS;
        end
        if (out_ready && r_s2_valid) begin
            r_out.anchor     <= r_s2_anchor;
            r_out.label      <= r_s2_label;
            r_out.score      <= r_s2_score;
            r_out.left       <= to_edge(w_cx0);
            r_out.top        <= to_edge(w_cy0);
            r_out.box_width  <= (w_cx1 > w_cx0) ? to_edge(w_cx1 - w_cx0) : '0;
            r_out.box_height <= (w_cy1 > w_cy0) ? to_edge(w_cy1 - w_cy0) : '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== design/detection_head_decode.sv =====
// top level of the detection head decoder: registers, front, queue, back
//
//  channel   direction  handshake                      payload
//  input     in         i_valid / o_stall              i_value
//  result    out        o_valid / i_stall              o_anchor_index .. o_box_height
//  config    in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  one value is taken per cycle while o_stall is low; the front holds box and arg-max in registers
//  a detection is pushed into the job queue when its row closes, then passes the back
//  pipeline registers (corners, scaling multiply, clamp) into the output register
//  o_stall rises only while the two-entry job queue is full
//  synchronous reset clears row position, anchor counter, queue and pipeline valids
`timescale 1ns / 1ps
`include "detection_head_decode_defines.svh"

module detection_head_decode import dhd_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int MAX_CLASSES   = MAX_CLASSES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [VALUE_W-1:0]     i_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [ANCHOR_W-1:0]    o_anchor_index,
    output logic [LABEL_W-1:0]     o_label,
    output logic [SCORE_W-1:0]     o_score,
    output logic [EDGE_W-1:0]      o_left,
    output logic [EDGE_W-1:0]      o_top,
    output logic [EDGE_W-1:0]      o_box_width,
    output logic [EDGE_W-1:0]      o_box_height,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [SCALE_W-1:0]  r_x_scale;
    logic [SCALE_W-1:0]  r_y_scale;
    logic [SIZE_W-1:0]   r_image_width;
    logic [SIZE_W-1:0]   r_image_height;
    logic [THRESH_W-1:0] r_score_threshold;
    logic [LABEL_W-1:0]  r_num_classes;
    logic [ANCHOR_W-1:0] r_num_anchors;

    t_front_cfg    w_front_cfg;
    t_geom_cfg     w_geom_cfg;
    logic          w_push;
    t_job          w_push_job;
    logic          w_pop;
    logic          w_q_valid;
    t_job          w_q_job;
    t_queue_status w_q_status;
    t_result       w_result;
    logic          w_q_fill;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale         <= RST_X_SCALE;
            r_y_scale         <= RST_Y_SCALE;
            r_image_width     <= RST_IMAGE_WIDTH;
            r_image_height    <= RST_IMAGE_HEIGHT;
            r_score_threshold <= RST_SCORE_THRESHOLD;
            r_num_classes     <= RST_NUM_CLASSES;
            r_num_anchors     <= RST_NUM_ANCHORS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_X_SCALE:         r_x_scale         <= i_cfg_data[SCALE_W-1:0];
                CFG_Y_SCALE:         r_y_scale         <= i_cfg_data[SCALE_W-1:0];
                CFG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_data[SIZE_W-1:0];
                CFG_SCORE_THRESHOLD: r_score_threshold <= i_cfg_data[THRESH_W-1:0];
                CFG_NUM_CLASSES:     r_num_classes     <= i_cfg_data[LABEL_W-1:0];
                CFG_NUM_ANCHORS:     r_num_anchors     <= i_cfg_data[ANCHOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_front_cfg.score_threshold = r_score_threshold;
    assign w_front_cfg.num_classes     = r_num_classes;
    assign w_front_cfg.num_anchors     = r_num_anchors;

    assign w_geom_cfg.x_scale      = r_x_scale;
    assign w_geom_cfg.y_scale      = r_y_scale;
    assign w_geom_cfg.image_width  = r_image_width;
    assign w_geom_cfg.image_height = r_image_height;

    dhd_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_front_cfg),
        .i_valid      (i_valid),
        .i_value      (i_value),
        .i_queue_full (w_q_status.full),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    dhd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_valid  (w_q_valid),
        .o_job    (w_q_job),
        .o_status (w_q_status)
    );

    dhd_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_geom_cfg),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_result    (w_result),
        .i_stall     (i_stall)
    );

    assign o_anchor_index = w_result.anchor;
    assign o_label        = w_result.label;
    assign o_score        = w_result.score;
    assign o_left         = w_result.left;
    assign o_top          = w_result.top;
    assign o_box_width    = w_result.box_width;
    assign o_box_height   = w_result.box_height;

    // push into the last free slot with nothing leaving
    assign w_q_fill = w_push && !w_pop && (w_q_status.count == QCNT_W'(QUEUE_DEPTH - 1));

    `DHD_ASSERT_NOW(a_no_push_when_full, w_push, !w_q_status.full)
    `DHD_ASSERT_NOW(a_pop_needs_job, w_pop, w_q_valid)
    `DHD_ASSERT_NEXT(a_queue_fills, w_q_fill, w_q_status.full)

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the detection head decoder
`timescale 1ns / 1ps

module testbench;
    import dhd_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 140;
    localparam int NUM_PHASES    = 10;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int NUM_OPENING   = 32;

    // index that maps to no register, must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum int {CHECK_MODEL, CHECK_TYPED, CHECK_SILENT, SET_CLASSES} t_step_kind;

    typedef struct {
        t_step_kind         kind;
        logic [VALUE_W-1:0] value;
        t_result            res;
    } t_step;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [VALUE_W-1:0]     i_value = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [ANCHOR_W-1:0]    o_anchor_index;
    logic [LABEL_W-1:0]     o_label;
    logic [SCORE_W-1:0]     o_score;
    logic [EDGE_W-1:0]      o_left;
    logic [EDGE_W-1:0]      o_top;
    logic [EDGE_W-1:0]      o_box_width;
    logic [EDGE_W-1:0]      o_box_height;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    detection_head_decode i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_anchor_index (o_anchor_index),
        .o_label        (o_label),
        .o_score        (o_score),
        .o_left         (o_left),
        .o_top          (o_top),
        .o_box_width    (o_box_width),
        .o_box_height   (o_box_height),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // register shadow
    longint cfg_x_scale      = longint'(RST_X_SCALE);
    longint cfg_y_scale      = longint'(RST_Y_SCALE);
    longint cfg_image_width  = longint'(RST_IMAGE_WIDTH);
    longint cfg_image_height = longint'(RST_IMAGE_HEIGHT);
    longint cfg_threshold    = longint'(RST_SCORE_THRESHOLD);
    longint cfg_num_classes  = longint'(RST_NUM_CLASSES);
    longint cfg_num_anchors  = longint'(RST_NUM_ANCHORS);

    // decoder state
    int     row_pos = 0;
    int     anchor_cnt = 0;
    longint box_raw [BOX_VALUES];
    longint best_val;
    int     best_cls;

    t_step      value_queue [$];
    t_result    detections_due [$];
    t_step      on_bus;
    t_idle_mode idle_mode = IDLE_NONE;
    int         hold_requests = 0;
    int         hold_served = 0;
    int         hold_left = 0;
    int         items_queued = 0;
    int         items_accepted = 0;
    int         detections_seen = 0;
    int         cfg_writes = 0;
    int         errors = 0;

    // directed opening: reset geometry, one class, then three, then a cut row
    t_step opening_steps [NUM_OPENING] = '{
        '{SET_CLASSES,  32'h0000_0001, '0},
        // plain box, largest score
        '{CHECK_MODEL,  32'h0064_0000, '0},
        '{CHECK_MODEL,  32'h0032_0000, '0},
        '{CHECK_MODEL,  32'h0014_0000, '0},
        '{CHECK_MODEL,  32'h000A_0000, '0},
        '{CHECK_TYPED,  32'h7FFF_FFFF,
          '{16'd0, 8'd0, 31'h7FFF_FFFF, 30'h005A_0000, 30'h002D_0000,
            30'h0014_0000, 30'h000A_0000}},
        // score equal to the threshold is dropped
        '{CHECK_MODEL,  32'h0000_0000, '0},
        '{CHECK_MODEL,  32'h0000_0000, '0},
        '{CHECK_MODEL,  32'h0000_0000, '0},
        '{CHECK_MODEL,  32'h0000_0000, '0},
        '{CHECK_SILENT, 32'h0000_4000, '0},
        // extreme box values, clamped on both sides
        '{CHECK_MODEL,  32'h7FFF_FFFF, '0},
        '{CHECK_MODEL,  32'h8000_0000, '0},
        '{CHECK_MODEL,  32'h7FFF_FFFF, '0},
        '{CHECK_MODEL,  32'h8000_0000, '0},
        '{CHECK_TYPED,  32'h0000_4001,
          '{16'd2, 8'd0, 31'd16385, 30'h0280_0000, 30'd0, 30'd0, 30'd0}},
        '{SET_CLASSES,  32'h0000_0003, '0},
        // negative width, tie between two classes
        '{CHECK_MODEL,  32'h0140_0000, '0},
        '{CHECK_MODEL,  32'h0140_0000, '0},
        '{CHECK_MODEL,  32'hFFD8_0000, '0},
        '{CHECK_MODEL,  32'h0000_0001, '0},
        '{CHECK_MODEL,  32'h8000_0000, '0},
        '{CHECK_MODEL,  32'h0009_0000, '0},
        '{CHECK_MODEL,  32'h0009_0000, '0},
        // row cut short by lowering the class count
        '{CHECK_MODEL,  32'hFFFF_FFFF, '0},
        '{CHECK_MODEL,  32'h0000_FFFF, '0},
        '{CHECK_MODEL,  32'h0000_0003, '0},
        '{CHECK_MODEL,  32'hFFFF_FFFD, '0},
        '{CHECK_MODEL,  32'h0001_0000, '0},
        '{CHECK_MODEL,  32'h0002_0000, '0},
        '{SET_CLASSES,  32'h0000_0001, '0},
        '{CHECK_MODEL,  32'h0000_8000, '0}
    };

    // append a value to the stimulus queue
    function automatic void add_value(input t_step s);
        value_queue.insert(value_queue.size(), s);
    endfunction

    // append an expected detection
    function automatic void add_expected(input t_result r);
        detections_due.insert(detections_due.size(), r);
    endfunction

    function automatic int class_count();
        if (cfg_num_classes < 1) return 1;
        if (cfg_num_classes > MAX_CLASSES_DEF) return MAX_CLASSES_DEF;
        return int'(cfg_num_classes);
    endfunction

    function automatic int idle_pct(input t_idle_mode m, input bit sender);
        case (m)
            IDLE_SENDER:   return sender ? 76 : 0;
            IDLE_RECEIVER: return sender ? 0 : 76;
            IDLE_BOTH:     return 37;
            default:       return 0;
        endcase
    endfunction

    // scaled corner, floored, clamped to the image
    function automatic longint scaled_edge(input longint raw, input longint scale,
                                           input longint size);
        longint lim;
        longint c;
        lim = size <<< FRACTION_BITS_DEF;
        c = (raw * scale) >>> FRACTION_BITS_DEF;
        if (c < 0) c = 0;
        if (c > lim) c = lim;
        return c;
    endfunction

    task automatic decode_value(input logic [VALUE_W-1:0] raw, output bit hit,
                                output t_result det);
        longint v, hw, hh, x0, x1, y0, y1, bw, bh;
        int last_pos;
        int p;
        v = longint'($signed(raw));
        hit = 1'b0;
        det = '0;
        last_pos = BOX_VALUES - 1 + class_count();
        if (row_pos < BOX_VALUES) begin
            box_raw[row_pos] = v;
            row_pos = row_pos + 1;
        end else begin
            p = (row_pos > last_pos) ? last_pos : row_pos;
            if (p == BOX_VALUES || v > best_val) begin
                best_val = v;
                best_cls = p - BOX_VALUES;
            end
            if (p < last_pos) begin
                row_pos = p + 1;
            end else begin
                if (best_val > cfg_threshold) begin
                    hw = box_raw[2] >>> 1;
                    hh = box_raw[3] >>> 1;
                    x0 = scaled_edge(box_raw[0] - hw, cfg_x_scale, cfg_image_width);
                    x1 = scaled_edge(box_raw[0] + hw, cfg_x_scale, cfg_image_width);
                    y0 = scaled_edge(box_raw[1] - hh, cfg_y_scale, cfg_image_height);
                    y1 = scaled_edge(box_raw[1] + hh, cfg_y_scale, cfg_image_height);
                    bw = (x1 > x0) ? x1 - x0 : 0;
                    bh = (y1 > y0) ? y1 - y0 : 0;
                    hit = 1'b1;
                    det.anchor     = anchor_cnt[ANCHOR_W-1:0];
                    det.label      = best_cls[LABEL_W-1:0];
                    det.score      = best_val[SCORE_W-1:0];
                    det.left       = x0[EDGE_W-1:0];
                    det.top        = y0[EDGE_W-1:0];
                    det.box_width  = bw[EDGE_W-1:0];
                    det.box_height = bh[EDGE_W-1:0];
                end
                row_pos = 0;
                anchor_cnt = (anchor_cnt + 1 >= cfg_num_anchors) ? 0 : anchor_cnt + 1;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // sender: predicts each accepted value, then offers the next one
    always @(posedge i_clk) begin
        bit      hit;
        t_result det;
        if (i_valid && !o_stall) begin
            decode_value(i_value, hit, det);
            case (on_bus.kind)
                CHECK_TYPED:  add_expected(on_bus.res);
                CHECK_SILENT: ;
                default: begin
                    if (hit) add_expected(det);
                end
            endcase
            items_accepted++;
        end
        if (!i_valid || !o_stall) begin
            if (value_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct(idle_mode, 1'b1)) begin
                on_bus = value_queue.pop_front();
                i_valid <= 1'b1;
                i_value <= on_bus.value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_stall     <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < idle_pct(idle_mode, 1'b0));
        end
    end

    // each detection transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            detections_seen++;
            if (detections_due.size() == 0) begin
                report_mismatch($sformatf("unexpected detection, anchor %0d", o_anchor_index));
            end else begin
                want = detections_due.pop_front();
                check_field("anchor_index", 32'(o_anchor_index), 32'(want.anchor));
                check_field("label", 32'(o_label), 32'(want.label));
                check_field("score", 32'(o_score), 32'(want.score));
                check_field("left", 32'(o_left), 32'(want.left));
                check_field("top", 32'(o_top), 32'(want.top));
                check_field("box_width", 32'(o_box_width), 32'(want.box_width));
                check_field("box_height", 32'(o_box_height), 32'(want.box_height));
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_X_SCALE:         cfg_x_scale      = longint'(data[SCALE_W-1:0]);
            CFG_Y_SCALE:         cfg_y_scale      = longint'(data[SCALE_W-1:0]);
            CFG_IMAGE_WIDTH:     cfg_image_width  = longint'(data[SIZE_W-1:0]);
            CFG_IMAGE_HEIGHT:    cfg_image_height = longint'(data[SIZE_W-1:0]);
            CFG_SCORE_THRESHOLD: cfg_threshold    = longint'(data[THRESH_W-1:0]);
            CFG_NUM_CLASSES:     cfg_num_classes  = longint'(data[LABEL_W-1:0]);
            CFG_NUM_ANCHORS:     cfg_num_anchors  = longint'(data[ANCHOR_W-1:0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // wait for every value taken and every detection back, then drain the pipeline
    task automatic settle();
        while (items_accepted != items_queued || detections_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sets bits above the register width now and then
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int w);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 3) != 0) return v;
        return (junk << w) | v;
    endfunction

    function automatic logic [VALUE_W-1:0] box_value(input int slot);
        int mag;
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: mag = -(($urandom_range(0, 50) << FRACTION_BITS_DEF) | $urandom_range(0, 65535));
            default: begin
                mag = (slot < 2) ? $urandom_range(0, 720) : $urandom_range(0, 400);
                mag = (mag << FRACTION_BITS_DEF) | $urandom_range(0, 65535);
            end
        endcase
        return mag;
    endfunction

    function automatic logic [VALUE_W-1:0] score_value(input logic [VALUE_W-1:0] prev);
        logic [VALUE_W-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: return VALUE_W'(cfg_threshold + $urandom_range(0, 3) - 1);
            1: return prev;
            2: return r;
            3: return $urandom_range(0, 131072);
            4: return {1'b0, r[VALUE_W-2:0]};
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    task automatic push_row(input int count);
        t_step              s;
        logic [VALUE_W-1:0] prev;
        prev = '0;
        for (int k = 0; k < count; k++) begin
            s.kind = CHECK_MODEL;
            s.res  = '0;
            if (k < BOX_VALUES) begin
                s.value = box_value(k);
            end else begin
                s.value = score_value(prev);
                prev = s.value;
            end
            add_value(s);
            items_queued++;
        end
    endtask

    task automatic program_phase(input int phase);
        logic [CFG_DATA_W-1:0] xs, ys, iw, ih, thr, ncls, nanch;
        if (phase == 1) begin
            xs = '0; ys = '0; iw = '0; ih = '0; thr = '0; ncls = '0; nanch = '0;
        end else if (phase == 2) begin
            xs = 24'hFF_FFFF; ys = 24'hFF_FFFF; iw = 16383; ih = 16383;
            thr = 131071; ncls = 255; nanch = 65535;
        end else begin
            if (phase == 3) write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
            case ($urandom_range(0, 3))
                0: xs = 65536;
                1: xs = CFG_DATA_W'($urandom_range(32768, 131072));
                2: xs = CFG_DATA_W'($urandom);
                default: xs = CFG_DATA_W'($urandom_range(0, 4096));
            endcase
            case ($urandom_range(0, 3))
                0: ys = 65536;
                1: ys = CFG_DATA_W'($urandom_range(32768, 131072));
                2: ys = CFG_DATA_W'($urandom);
                default: ys = CFG_DATA_W'($urandom_range(0, 4096));
            endcase
            case ($urandom_range(0, 3))
                0: iw = CFG_DATA_W'($urandom_range(1, 1000));
                1: iw = 8192;
                2: iw = 1;
                default: iw = 640;
            endcase
            case ($urandom_range(0, 3))
                0: ih = CFG_DATA_W'($urandom_range(1, 1000));
                1: ih = 8192;
                2: ih = 1;
                default: ih = 640;
            endcase
            case ($urandom_range(0, 3))
                0: thr = 16384;
                1: thr = 65536;
                2: thr = CFG_DATA_W'($urandom_range(0, 131071));
                default: thr = CFG_DATA_W'($urandom_range(0, 4096));
            endcase
            case ($urandom_range(0, 3))
                0: nanch = CFG_DATA_W'($urandom_range(1, 5));
                1: nanch = CFG_DATA_W'($urandom_range(1, 60));
                2: nanch = 8400;
                default: nanch = 1;
            endcase
            ncls  = (phase == 5) ? CFG_DATA_W'(80) : CFG_DATA_W'($urandom_range(1, 6));
            iw    = with_junk(iw, SIZE_W);
            ih    = with_junk(ih, SIZE_W);
            thr   = with_junk(thr, THRESH_W);
            ncls  = with_junk(ncls, LABEL_W);
            nanch = with_junk(nanch, ANCHOR_W);
        end
        write_reg(CFG_X_SCALE, xs);
        write_reg(CFG_Y_SCALE, ys);
        write_reg(CFG_IMAGE_WIDTH, iw);
        write_reg(CFG_IMAGE_HEIGHT, ih);
        write_reg(CFG_SCORE_THRESHOLD, thr);
        write_reg(CFG_NUM_CLASSES, ncls);
        write_reg(CFG_NUM_ANCHORS, nanch);
    endtask

    initial begin
        int classes;
        int row_len;
        int sent;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_steps[n]) begin
            if (opening_steps[n].kind == SET_CLASSES) begin
                settle();
                write_reg(CFG_NUM_CLASSES, opening_steps[n].value[CFG_DATA_W-1:0]);
            end else begin
                add_value(opening_steps[n]);
                items_queued++;
            end
        end
        settle();

        for (int phase = 1; phase <= NUM_PHASES; phase++) begin
            program_phase(phase);
            idle_mode = t_idle_mode'(phase % 4);
            // long receiver hold-off so the job queue fills and stalls the input
            if (phase % 4 == 0) hold_requests++;
            classes = class_count();
            row_len = BOX_VALUES + classes;
            sent = 0;
            while (sent < PHASE_ITEMS || sent < 2 * row_len) begin
                push_row(row_len);
                sent += row_len;
            end
            // leave a row open so the next settings land mid-row
            if ($urandom_range(0, 1) != 0)
                push_row($urandom_range(1, (row_len - 1 < 12) ? row_len - 1 : 12));
            settle();
        end

        $display("covered %0d values over %0d phases with %0d register writes",
                 items_accepted, NUM_PHASES + 1, cfg_writes);
        $display("%0d detections compared, %0d mismatches", detections_seen, errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d detections still due", detections_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/dhd_pkg.sv
design/dhd_front.sv
design/dhd_queue.sv
design/dhd_back.sv
design/detection_head_decode.sv
dv/testbench.sv
